/* design/pmd_pkg.sv */
package pmd_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_PROP    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_INTEG   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_DERIV   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_BAND   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_TICKS = 3'd4;

  localparam logic signed [15:0] GAIN_PROP_RST    = 16'sd256;
  localparam logic signed [15:0] GAIN_INTEG_RST   = 16'sd0;
  localparam logic signed [15:0] GAIN_DERIV_RST   = 16'sd0;
  localparam logic [15:0]        ERROR_BAND_RST   = 16'd5;
  localparam logic [15:0]        SAMPLE_TICKS_RST = 16'd10;

  // request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_ZERO  = 2'd2;

  localparam logic signed [7:0] DUTY_MAX = 8'sd100;
  localparam logic signed [7:0] DUTY_MIN = -8'sd100;

  // what the late stage does with the duty level
  typedef enum logic [1:0] {
    DUTY_KEEP,
    DUTY_ZERO,
    DUTY_NEW
  } duty_op_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [31:0]  target;
    logic signed [15:0]  encoder_delta;
  } req_t;

  typedef struct packed {
    logic [6:0]          compare_value;
    logic                direction;
    logic                busy_res;
    logic                done_res;
    logic signed [31:0]  position;
  } res_t;

endpackage

/* design/pid_position_motor_drive.sv */
// Position PID for one DC motor. Requests (start move, timer tick, zero
// position) are taken one per clock unless the pipeline stalls, each
// giving exactly one result, in order. The state is updated as a request
// leaves the input register, so requests may follow in every cycle; the
// products of the Q8.8 gains are registered in the next stage and the
// duty level in the result register. A result shows the PWM compare
// value and direction, busy and done flags and the position after that
// request. Configuration is written through cfg_we/cfg_index/cfg_data and
// must only change while no request is in flight.
module pid_position_motor_drive
  import pmd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req,
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic signed [65:0] ACC_HI = 66'sd25856;
  localparam logic signed [65:0] ACC_LO = -66'sd25856;

  // configuration
  logic signed [15:0] gain_prop;
  logic signed [15:0] gain_integ;
  logic signed [15:0] gain_deriv;
  logic [15:0]        error_band;
  logic [15:0]        sample_ticks;

  // controller state
  logic signed [31:0] position_count;
  logic [15:0]        pending_count;
  logic signed [31:0] setpoint_reg;
  logic signed [47:0] error_sum;
  logic signed [31:0] last_error;
  logic [15:0]        tick_count;
  logic               moving;
  logic               finished;
  logic signed [7:0]  duty_level;

  logic signed [31:0] position_count_next;
  logic [15:0]        pending_count_next;
  logic signed [31:0] setpoint_reg_next;
  logic signed [47:0] error_sum_next;
  logic signed [31:0] last_error_next;
  logic [15:0]        tick_count_next;
  logic               moving_next;
  logic               finished_next;
  logic signed [7:0]  duty_level_next;

  // pipeline registers
  logic               v0, v1, v2;
  req_t               req_q;
  logic signed [31:0] s1_err;
  logic signed [47:0] s1_sum;
  logic signed [32:0] s1_diff;
  duty_op_t           s1_op;
  logic               s1_busy, s1_done;
  logic signed [31:0] s1_pos;
  logic signed [47:0] p_prop;
  logic signed [63:0] p_integ;
  logic signed [48:0] p_deriv;
  duty_op_t           s2_op;
  logic               s2_busy, s2_done;
  logic signed [31:0] s2_pos;

  logic adv1, adv2, adv3, fire0;

  // stage one combinational values
  logic [15:0]        pend_sum;
  logic [15:0]        tick_inc;
  logic signed [32:0] fold33;
  logic signed [31:0] pos_fold;
  logic signed [32:0] err33;
  logic signed [31:0] err;
  logic signed [48:0] sum49;
  logic signed [47:0] sum_sat;
  logic signed [32:0] diff33;
  logic [32:0]        mag33;
  logic               in_band;
  logic               run_pid;
  duty_op_t           op_next;

  // late stage
  logic signed [65:0] acc;
  logic signed [7:0]  duty_trunc;
  logic [7:0]         cmp8;
  res_t               res_next;

  // handshake chain
  assign adv3      = !res_valid || res_ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req_ready = !v0 || adv1;
  assign fire0     = v0 && adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop    <= GAIN_PROP_RST;
      gain_integ   <= GAIN_INTEG_RST;
      gain_deriv   <= GAIN_DERIV_RST;
      error_band   <= ERROR_BAND_RST;
      sample_ticks <= SAMPLE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_PROP:    gain_prop    <= cfg_data;
        CFG_GAIN_INTEG:   gain_integ   <= cfg_data;
        CFG_GAIN_DERIV:   gain_deriv   <= cfg_data;
        CFG_ERROR_BAND:   error_band   <= cfg_data;
        CFG_SAMPLE_TICKS: sample_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // state update for the request in the input register
  always_comb begin
    pend_sum = pending_count + req_q.encoder_delta;
    tick_inc = tick_count + 16'd1;
    run_pid  = moving && (tick_inc >= sample_ticks);

    fold33 = {position_count[31], position_count} + {{17{pend_sum[15]}}, pend_sum};
    if (fold33[32] != fold33[31]) begin
      pos_fold = fold33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      pos_fold = fold33[31:0];
    end

    err33 = {setpoint_reg[31], setpoint_reg} - {pos_fold[31], pos_fold};
    if (err33[32] != err33[31]) begin
      err = err33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err = err33[31:0];
    end

    sum49 = {error_sum[47], error_sum} + {{17{err[31]}}, err};
    if (sum49[48] != sum49[47]) begin
      sum_sat = sum49[48] ? 48'sh8000_0000_0000 : 48'sh7fff_ffff_ffff;
    end else begin
      sum_sat = sum49[47:0];
    end

    diff33  = {err[31], err} - {last_error[31], last_error};
    mag33   = err[31] ? (33'd0 - {err[31], err}) : {1'b0, err};
    in_band = mag33 < {17'd0, error_band};

    position_count_next = position_count;
    pending_count_next  = pending_count;
    setpoint_reg_next   = setpoint_reg;
    error_sum_next      = error_sum;
    last_error_next     = last_error;
    tick_count_next     = tick_count;
    moving_next         = moving;
    finished_next       = finished;
    op_next             = DUTY_KEEP;

    case (req_q.req_type)
      REQ_START: begin
        setpoint_reg_next = req_q.target;
        finished_next     = 1'b0;
        moving_next       = 1'b1;
        tick_count_next   = 16'd0;
      end
      REQ_TICK: begin
        pending_count_next = pend_sum;
        if (moving) begin
          tick_count_next = tick_inc;
          if (run_pid) begin
            tick_count_next     = 16'd0;
            position_count_next = pos_fold;
            pending_count_next  = 16'd0;
            error_sum_next      = sum_sat;
            last_error_next     = in_band ? 32'sd0 : err;
            finished_next       = finished || in_band;
            op_next             = DUTY_NEW;
          end
          if (finished_next) begin
            op_next     = DUTY_ZERO;
            moving_next = 1'b0;
          end
        end
      end
      REQ_ZERO: begin
        position_count_next = 32'sd0;
        pending_count_next  = 16'd0;
        op_next             = DUTY_ZERO;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= 32'sd0;
      pending_count  <= 16'd0;
      setpoint_reg   <= 32'sd0;
      error_sum      <= 48'sd0;
      last_error     <= 32'sd0;
      tick_count     <= 16'd0;
      moving         <= 1'b0;
      finished       <= 1'b0;
    end else if (fire0) begin
      position_count <= position_count_next;
      pending_count  <= pending_count_next;
      setpoint_reg   <= setpoint_reg_next;
      error_sum      <= error_sum_next;
      last_error     <= last_error_next;
      tick_count     <= tick_count_next;
      moving         <= moving_next;
      finished       <= finished_next;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (req_ready) v0 <= req_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
      if (adv3) res_valid <= v2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_ready && req_valid) req_q <= req;
    if (fire0) begin
      s1_err  <= err;
      s1_sum  <= sum_sat;
      s1_diff <= diff33;
      s1_op   <= op_next;
      s1_busy <= moving_next;
      s1_done <= finished_next;
      s1_pos  <= position_count_next;
    end
    if (v1 && adv2) begin
      p_prop  <= gain_prop * s1_err;
      p_integ <= gain_integ * s1_sum;
      p_deriv <= gain_deriv * s1_diff;
      s2_op   <= s1_op;
      s2_busy <= s1_busy;
      s2_done <= s1_done;
      s2_pos  <= s1_pos;
    end
    if (v2 && adv3) res <= res_next;
  end

  // sum, truncate toward zero and clamp for a new duty level (or keep or zero it), then compare value and direction
  always_comb begin
    acc = {{18{p_prop[47]}}, p_prop} + {{2{p_integ[63]}}, p_integ}
        + {{17{p_deriv[48]}}, p_deriv};
    duty_trunc = acc[15:8] + {7'd0, acc[65] && (acc[7:0] != 8'd0)};
    case (s2_op)
      DUTY_KEEP: duty_level_next = duty_level;
      DUTY_ZERO: duty_level_next = 8'sd0;
      DUTY_NEW: begin
        if (acc >= ACC_HI) begin
          duty_level_next = DUTY_MAX;
        end else if (acc <= ACC_LO) begin
          duty_level_next = DUTY_MIN;
        end else begin
          duty_level_next = duty_trunc;
        end
      end
      default: duty_level_next = duty_level;
    endcase

    if (duty_level_next > 8'sd0) begin
      cmp8 = DUTY_MAX - duty_level_next;
    end else if (duty_level_next < 8'sd0) begin
      cmp8 = 8'sd0 - duty_level_next;
    end else begin
      cmp8 = 8'd0;
    end

    res_next.compare_value = cmp8[6:0];
    res_next.direction     = duty_level_next > 8'sd0;
    res_next.busy_res      = s2_busy;
    res_next.done_res      = s2_done;
    res_next.position      = s2_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_level <= 8'sd0;
    end else if (v2 && adv3) begin
      duty_level <= duty_level_next;
    end
  end

`ifndef SYNTH
  // a move that has finished is never still in progress
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    !(moving && finished))
    else $error("moving and finished both set");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    duty_level <= DUTY_MAX && duty_level >= DUTY_MIN)
    else $error("duty level out of range");

  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    fire0 && req_q.req_type == REQ_ZERO |=> position_count == 32'sd0 &&
    pending_count == 16'd0)
    else $error("zero position request did not clear counts");

  a_duty_zero: assert property (@(posedge clk) disable iff (rst)
    v2 && adv3 && s2_op == DUTY_ZERO |=> duty_level == 8'sd0)
    else $error("duty level not forced to zero");

  a_dir_cmp: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.direction |-> res.compare_value < 7'd100)
    else $error("compare value out of range for positive duty");
`endif

endmodule

/* verif/pid_position_motor_drive_test.sv */
module pid_position_motor_drive_test;
  import pmd_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint S48_HI = 64'sd140737488355327;
  localparam longint S48_LO = -64'sd140737488355328;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pid_position_motor_drive i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // controller copy kept by the testbench
  logic signed [15:0] kp_q88 = GAIN_PROP_RST;
  logic signed [15:0] ki_q88 = GAIN_INTEG_RST;
  logic signed [15:0] kd_q88 = GAIN_DERIV_RST;
  logic [15:0] band_lim = ERROR_BAND_RST;
  logic [15:0] sample_period = SAMPLE_TICKS_RST;

  logic signed [31:0] shaft_pos = '0;
  logic [15:0] pend_delta = '0;
  logic signed [31:0] goal_pos = '0;
  logic signed [47:0] integ_sum = '0;
  logic signed [31:0] prev_err = '0;
  logic signed [7:0] duty_now = '0;
  logic [15:0] tick_cnt = '0;
  logic in_motion = 1'b0;
  logic arrived = 1'b0;

  req_t req_backlog[$];
  res_t expected_drive[$];
  res_t want;

  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned n_queued = 0;
  int unsigned n_start = 0;
  int unsigned n_tick = 0;
  int unsigned n_home = 0;
  int unsigned n_finish = 0;
  int unsigned n_pos_sat = 0;
  int unsigned n_sum_sat = 0;
  int unsigned n_settings = 0;
  int unsigned hold = 0;
  int unsigned stall = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit rush = 1'b0;
  longint est_pos = 0;

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(15, 4);
    return $urandom_range(50, 20);
  endfunction

  task automatic drive_model_step(input req_t r);
    longint e, acc, sum_next, pos_next;
    res_t o;
    case (r.req_type)
      REQ_START: begin
        goal_pos = r.target;
        arrived = 1'b0;
        in_motion = 1'b1;
        tick_cnt = '0;
        n_start++;
      end
      REQ_TICK: begin
        n_tick++;
        pend_delta = pend_delta + r.encoder_delta;
        if (in_motion) begin
          tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= sample_period) begin
            tick_cnt = '0;
            pos_next = longint'(shaft_pos) + longint'($signed(pend_delta));
            if (pos_next > S32_HI || pos_next < S32_LO) n_pos_sat++;
            shaft_pos = 32'(clamp_range(pos_next, S32_LO, S32_HI));
            pend_delta = '0;
            e = clamp_range(longint'(goal_pos) - longint'(shaft_pos), S32_LO, S32_HI);
            sum_next = longint'(integ_sum) + e;
            if (sum_next > S48_HI || sum_next < S48_LO) n_sum_sat++;
            integ_sum = 48'(clamp_range(sum_next, S48_LO, S48_HI));
            acc = longint'(kp_q88) * e + longint'(ki_q88) * longint'(integ_sum)
                + longint'(kd_q88) * (e - longint'(prev_err));
            duty_now = 8'(clamp_range(acc / 256, longint'(DUTY_MIN), longint'(DUTY_MAX)));
            prev_err = 32'(e);
            if (((e < 0) ? -e : e) < longint'(band_lim)) begin
              arrived = 1'b1;
              prev_err = '0;
              n_finish++;
            end
          end
          if (arrived) begin
            duty_now = '0;
            in_motion = 1'b0;
          end
        end
      end
      REQ_ZERO: begin
        n_home++;
        shaft_pos = '0;
        pend_delta = '0;
        duty_now = '0;
      end
      default: ;
    endcase
    o = '0;
    if (duty_now > 0) begin
      o.compare_value = 7'(DUTY_MAX - duty_now);
      o.direction = 1'b1;
    end else if (duty_now < 0) begin
      o.compare_value = 7'(-duty_now);
    end
    o.busy_res = in_motion;
    o.done_res = arrived;
    o.position = shaft_pos;
    expected_drive.push_back(o);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      n_errors++;
      if (n_errors <= 30)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) drive_model_step(req);
      if (!req_valid || req_ready) begin
        if (hold != 0) begin
          hold--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          req <= req_backlog.pop_front();
          req_valid <= 1'b1;
          if ($urandom_range(59, 0) == 0) tx_calm = !tx_calm;
          hold = (rush || tx_calm) ? 0 : pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        n_results++;
        if (expected_drive.size() == 0) begin
          n_errors++;
          if (n_errors <= 30)
            $display("%0t: result with no transaction pending, expected none, got %p",
                     $time, res);
        end else begin
          want = expected_drive.pop_front();
          check_field("compare_value", want.compare_value, res.compare_value);
          check_field("direction", want.direction, res.direction);
          check_field("busy_res", want.busy_res, res.busy_res);
          check_field("done_res", want.done_res, res.done_res);
          check_field("position", want.position, res.position);
        end
      end
      if ($urandom_range(199, 0) == 0) rx_calm = !rx_calm;
      if (stall != 0) begin
        stall--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        if (!rush && !rx_calm && $urandom_range(5, 0) == 0) stall = pick_gap();
      end
    end
  end

  task automatic enqueue_req(input logic [1:0] kind, input logic [31:0] tgt,
                             input logic [15:0] delta);
    req_t t;
    t.req_type = kind;
    t.target = tgt;
    t.encoder_delta = delta;
    req_backlog.push_back(t);
    if (kind != REQ_UNUSED) n_queued++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (req_backlog.size() != 0 || req_valid || expected_drive.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_GAIN_PROP:    kp_q88 = val;
      CFG_GAIN_INTEG:   ki_q88 = val;
      CFG_GAIN_DERIV:   kd_q88 = val;
      CFG_ERROR_BAND:   band_lim = val;
      CFG_SAMPLE_TICKS: sample_period = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [15:0] kp, input logic [15:0] ki,
                           input logic [15:0] kd, input logic [15:0] band,
                           input logic [15:0] period);
    write_reg(CFG_GAIN_PROP, kp);
    write_reg(CFG_GAIN_INTEG, ki);
    write_reg(CFG_GAIN_DERIV, kd);
    write_reg(CFG_ERROR_BAND, band);
    write_reg(CFG_SAMPLE_TICKS, period);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // start a move and feed encoder counts that close in on the target,
  // like a motor that follows its drive
  task automatic enqueue_move();
    longint goal, step;
    int unsigned n_ticks, i;
    logic signed [15:0] rnd16;
    goal = est_pos + longint'($urandom_range(6000, 0)) - 3000;
    enqueue_req(REQ_START, goal[31:0], 16'($urandom));
    if (sample_period == 0) n_ticks = $urandom_range(30, 4);
    else if (sample_period <= 8)
      n_ticks = sample_period * $urandom_range(8, 2) + $urandom_range(3, 0);
    else n_ticks = $urandom_range(40, 5);
    for (i = 0; i < n_ticks; i++) begin
      if ($urandom_range(19, 0) == 0) begin
        rnd16 = 16'($urandom);
        step = rnd16;
      end else begin
        step = clamp_range((goal - est_pos) / 4, -300, 300)
             + longint'($urandom_range(6, 0)) - 3;
      end
      est_pos += step;
      enqueue_req(REQ_TICK, $urandom, step[15:0]);
    end
  endtask

  task automatic fill_phase(input int unsigned quota);
    int unsigned first, r;
    logic signed [15:0] rnd16;
    first = n_queued;
    while (n_queued - first < quota) begin
      r = $urandom_range(99, 0);
      if (r < 8) begin
        enqueue_req(REQ_ZERO, $urandom, 16'($urandom));
        est_pos = 0;
      end else if (r < 11) begin
        enqueue_req(REQ_UNUSED, $urandom, 16'($urandom));
      end else if (r < 14) begin
        enqueue_req(REQ_START, $urandom, 16'($urandom));
      end else if (r < 20) begin
        rnd16 = 16'($urandom);
        est_pos += rnd16;
        enqueue_req(REQ_TICK, $urandom, rnd16);
      end else begin
        enqueue_move();
      end
    end
    wait_idle();
  endtask

  initial begin
    int unsigned ph, i;
    logic [15:0] kp, ki, kd, band, period;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: idle ticks with extreme deltas, home, unused code, full-scale moves
    enqueue_req(REQ_TICK, 32'h0000_0000, 16'sh7FFF);
    enqueue_req(REQ_TICK, 32'hFFFF_FFFF, 16'sh8000);
    enqueue_req(REQ_ZERO, 32'h0, 16'h0);
    enqueue_req(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    enqueue_req(REQ_START, 32'h7FFF_FFFF, 16'h0);
    enqueue_req(REQ_TICK, 32'h0, 16'sh7FFF);
    enqueue_req(REQ_TICK, 32'h0, 16'sh8000);
    enqueue_req(REQ_TICK, 32'h0, 16'hFFFF);
    enqueue_req(REQ_TICK, 32'h0, 16'h0);
    enqueue_req(REQ_TICK, 32'h0, 16'h1);
    enqueue_req(REQ_TICK, 32'h0, 16'd100);
    enqueue_req(REQ_TICK, 32'h0, -16'sd100);
    enqueue_req(REQ_TICK, 32'h0, 16'd2);
    enqueue_req(REQ_TICK, 32'h0, 16'd3);
    enqueue_req(REQ_TICK, 32'h0, 16'd4);
    enqueue_req(REQ_START, 32'h8000_0000, 16'h0);
    for (i = 0; i < 10; i++) enqueue_req(REQ_TICK, 32'h0, 16'h0);
    wait_idle();
    est_pos = 8;

    // extremes: widest band, so a sample less than 65535 counts from the target ends the move at once
    set_gains(16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF, 16'd1);
    fill_phase(110);
    // extremes the other way: no band, longest sample period
    set_gains(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h0000, 16'hFFFF);
    fill_phase(60);
    // zero sample period runs the controller on every tick while a move is in progress
    set_gains(16'd512, 16'd1, 16'd64, 16'd20, 16'd0);
    fill_phase(120);

    for (ph = 0; ph < 7; ph++) begin
      kp = ($urandom_range(9, 0) < 7) ? 16'($urandom_range(1024, 32)) : 16'($urandom);
      ki = ($urandom_range(9, 0) < 6) ? 16'($urandom_range(8, 0)) :
           ($urandom_range(1, 0) == 0) ? 16'h0 : 16'($urandom);
      kd = ($urandom_range(9, 0) < 6) ? 16'($urandom_range(400, 0)) : 16'($urandom);
      band = ($urandom_range(3, 0) != 0) ? 16'($urandom_range(80, 2)) : 16'($urandom);
      period = ($urandom_range(9, 0) != 0) ? 16'($urandom_range(6, 1)) :
               16'($urandom_range(65535, 1));
      set_gains(kp, ki, kd, band, period);
      fill_phase(100);
    end

    // short run at full speed with full-scale deltas
    set_gains(16'd256, 16'd1, 16'd0, 16'd0, 16'd1);
    rush = 1'b1;
    enqueue_req(REQ_START, 32'h8000_0000, 16'h0);
    for (i = 0; i < 30; i++) enqueue_req(REQ_TICK, 32'h0, 16'sh7FFF);
    wait_idle();
    rush = 1'b0;
    enqueue_req(REQ_ZERO, 32'h0, 16'h0);
    enqueue_req(REQ_TICK, 32'h0, 16'sh8000);
    enqueue_req(REQ_TICK, 32'h0, 16'sh8000);
    wait_idle();

    $display("covered %0d transactions (%0d starts, %0d ticks, %0d homes) over %0d gain settings",
             n_results, n_start, n_tick, n_home, n_settings);
    $display("%0d moves settled in band; position saturated %0d times, integral %0d times",
             n_finish, n_pos_sat, n_sum_sat);
    if (n_errors == 0) begin
      $display("pid_position_motor_drive_test OK");
    end else begin
      $display("pid_position_motor_drive_test NOT OK");
    end
    $finish;
  end

  initial begin
    #24000000;
    $display("timeout with %0d transactions still queued and %0d results outstanding",
             req_backlog.size(), expected_drive.size());
    $display("pid_position_motor_drive_test NOT OK");
    $finish;
  end

endmodule

/* sim.f */
design/pmd_pkg.sv
design/pid_position_motor_drive.sv
verif/pid_position_motor_drive_test.sv
